@@ rtl/scba_pkg.sv @@
// Package: shared constants and types for the size-class block allocator.
`timescale 1ns / 1ps
package scba_pkg;
  localparam int PAGE_SIZE    = 8192;
  localparam int NUM_PAGES    = 64;
  localparam int MIN_BLOCK    = 32;
  localparam int NUM_CLASSES  = 9;
  localparam int HEADER_BYTES = 4;

  localparam int ADDR_W = 19;
  localparam int SIZE_W = 13;
  localparam int CNT_W  = 15;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TOO_LARGE = 2'd1,
    ST_NO_PAGES  = 2'd2,
    ST_NONE_OUT  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CARVE,
    S_READ,
    S_POP,
    S_RESP
  } state_t;
endpackage

@@ rtl/scba_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module scba_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read, read data registered
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

@@ rtl/size_class_block_allocator.sv @@
// Top level: size-class block allocator with link memory and carving sequencer.
//
// Usage: one request beat on in_* (func, req_size, block_addr) gives exactly
// one response beat on out_* (result_addr, status, all_released).
// A free or an error is settled at the accepting edge. Its response beat is
// valid the next cycle, so such requests can follow back to back.
// An allocation from a non-empty class goes from acceptance to the response
// register through S_READ to read the link memory at the list head, S_POP
// to pop, and S_RESP to present.
// An allocation from an empty class first carves a fresh page, one link
// written per cycle through the single write port of the link memory, so it
// writes (PAGE_SIZE - HEADER_BYTES) / block_size links (up to 255) first.
// One request is worked at a time; in_tready is high only when the block
// is idle and the response register is free or being emptied.
// A stalled out_tready holds the response register and blocks new requests.
// Reset clears the list heads, page count and outstanding count; the link
// memory needs no clearing since a link is only read after being written.
`timescale 1ns / 1ps
module size_class_block_allocator #(
  parameter int PAGE_SIZE    = scba_pkg::PAGE_SIZE,
  parameter int NUM_PAGES    = scba_pkg::NUM_PAGES,
  parameter int MIN_BLOCK    = scba_pkg::MIN_BLOCK,
  parameter int NUM_CLASSES  = scba_pkg::NUM_CLASSES,
  parameter int HEADER_BYTES = scba_pkg::HEADER_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [12:0] req_size, [31:13] block_addr
  input  logic        in_tuser,   // [0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [18:0] result_addr, [20:19] status, [23:21] zero
  output logic        out_tuser   // [0] all_released
);
  localparam int AW       = scba_pkg::ADDR_W;
  localparam int CW       = scba_pkg::CNT_W;
  localparam int LDEPTH   = NUM_PAGES * PAGE_SIZE / MIN_BLOCK;
  localparam int LW       = $clog2(LDEPTH);
  localparam int MINSH    = $clog2(MIN_BLOCK);
  localparam int PAGESH   = $clog2(PAGE_SIZE);
  localparam int CLW      = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int PW       = $clog2(NUM_PAGES + 1);
  localparam int NW       = $clog2(PAGE_SIZE);
  localparam int USABLE   = PAGE_SIZE - HEADER_BYTES;
  localparam logic [CW-1:0] CMAX = {CW{1'b1}};

  // Unpack the request
  logic              in_func;
  logic [12:0]       in_size;
  logic [AW-1:0]     in_addr;
  assign in_func = in_tuser;
  assign in_size = in_tdata[12:0];
  assign in_addr = in_tdata[31:13];

  scba_pkg::state_t state_r, state_nxt;

  // Control and payload registers
  logic [AW:0]       heads_r [NUM_CLASSES];
  logic [PW-1:0]     pages_r;
  logic [CW-1:0]     outst_r;
  logic [AW-1:0]     addr_r;
  logic [CLW-1:0]    cls_r;
  logic [AW-1:0]     blk_r;
  logic [AW-1:0]     carve_a_r;
  logic [NW-1:0]     carve_n_r;
  logic              ovld_r;
  logic [AW-1:0]     ores_r;
  scba_pkg::status_t ost_r;
  logic              orel_r;

  // Size to class: smallest class holding size plus header
  logic [14:0]    need;
  logic [CLW-1:0] cls_c;
  logic [AW-1:0]  blk_c;
  logic           big_c;
  logic [14:0]    bsz;
  always_comb begin
    need  = 15'(in_size) + 15'(HEADER_BYTES);
    cls_c = '0;
    blk_c = '0;
    big_c = 1'b1;
    bsz   = '0;
    for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
      bsz = 15'(MIN_BLOCK << c);
      if (need <= bsz && (MIN_BLOCK << c) <= USABLE) begin
        cls_c = CLW'(c);
        blk_c = AW'(MIN_BLOCK << c);
        big_c = 1'b0;
      end
    end
  end

  // Link memory ports
  logic          lw_en;
  logic [LW-1:0] lw_addr, lr_addr;
  logic [AW:0]   lw_data, lr_data;

  scba_ram #(.WIDTH(AW + 1), .DEPTH(LDEPTH)) u_links (
    .clk    (clk),
    .wr_en  (lw_en),
    .wr_addr(lw_addr),
    .wr_data(lw_data),
    .rd_addr(lr_addr),
    .rd_data(lr_data)
  );

  logic accept, out_free;
  assign out_free  = !ovld_r || out_tready;
  assign in_tready = (state_r == scba_pkg::S_IDLE) && out_free;
  assign accept    = in_tvalid && in_tready;

  logic [AW:0]   head_sel;
  logic [PW-1:0] pages_eff;
  logic [AW-1:0] page_base;
  logic          last_link;
  logic          ovld_set;
  assign head_sel  = heads_r[cls_c];
  assign pages_eff = (pages_r == '0) ? PW'(1) : pages_r;
  assign page_base = AW'((AW + PW)'(pages_eff) << PAGESH) + AW'(HEADER_BYTES);
  assign last_link = (carve_n_r == NW'(1));

  // Load the response register: settled at acceptance or after the pop
  assign ovld_set = (state_r == scba_pkg::S_RESP && out_free) ||
                    (accept && (in_func || big_c ||
                                (!head_sel[AW] && pages_eff >= PW'(NUM_PAGES))));

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      scba_pkg::S_IDLE: begin
        if (accept && !in_func && !big_c) begin
          if (head_sel[AW]) begin
            state_nxt = scba_pkg::S_READ;
          end else if (pages_eff < PW'(NUM_PAGES)) begin
            state_nxt = scba_pkg::S_CARVE;
          end
        end
      end
      scba_pkg::S_CARVE: if (last_link) state_nxt = scba_pkg::S_READ;
      scba_pkg::S_READ:  state_nxt = scba_pkg::S_POP;
      scba_pkg::S_POP:   state_nxt = scba_pkg::S_RESP;
      scba_pkg::S_RESP:  if (out_free) state_nxt = scba_pkg::S_IDLE;
      default:           state_nxt = scba_pkg::S_IDLE;
    endcase
  end

  // Link memory access
  always_comb begin
    lw_en   = 1'b0;
    lw_addr = in_addr[MINSH +: LW];
    lw_data = head_sel;
    lr_addr = addr_r[MINSH +: LW];
    case (state_r)
      scba_pkg::S_IDLE: begin
        lw_en = accept && in_func && outst_r != '0 && !big_c;
      end
      scba_pkg::S_CARVE: begin
        lw_en   = 1'b1;
        lw_addr = carve_a_r[MINSH +: LW];
        lw_data = last_link ? '0 : {1'b1, carve_a_r + blk_r};
      end
      default: ;
    endcase
  end

  // Sequencer and state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= scba_pkg::S_IDLE;
      pages_r <= '0;
      outst_r <= '0;
      ovld_r  <= 1'b0;
      for (int c = 0; c < NUM_CLASSES; c++) heads_r[c] <= '0;
    end else begin
      state_r <= state_nxt;
      if (ovld_set) ovld_r <= 1'b1;
      else if (out_tready) ovld_r <= 1'b0;
      case (state_r)
        scba_pkg::S_IDLE: begin
          if (accept) begin
            cls_r  <= cls_c;
            blk_r  <= blk_c;
            ores_r <= '0;
            orel_r <= in_func && outst_r == CW'(1) && !big_c;
            if (!in_func) begin
              if (big_c) begin
                ost_r <= scba_pkg::ST_TOO_LARGE;
              end else if (head_sel[AW]) begin
                ost_r   <= scba_pkg::ST_OK;
                pages_r <= pages_eff;
                addr_r  <= head_sel[AW-1:0];
              end else if (pages_eff >= PW'(NUM_PAGES)) begin
                ost_r   <= scba_pkg::ST_NO_PAGES;
                pages_r <= pages_eff;
              end else begin
                ost_r     <= scba_pkg::ST_OK;
                pages_r   <= pages_eff + PW'(1);
                addr_r    <= page_base;
                carve_a_r <= page_base;
                carve_n_r <= NW'(USABLE / (MIN_BLOCK << 0) >> cls_c);
              end
            end else if (outst_r == '0) begin
              ost_r <= scba_pkg::ST_NONE_OUT;
            end else if (big_c) begin
              ost_r <= scba_pkg::ST_TOO_LARGE;
            end else begin
              ost_r   <= scba_pkg::ST_OK;
              outst_r <= outst_r - CW'(1);
              if (outst_r == CW'(1)) begin
                pages_r <= '0;
                for (int c = 0; c < NUM_CLASSES; c++) heads_r[c] <= '0;
              end else begin
                heads_r[cls_c] <= {1'b1, in_addr};
              end
            end
          end
        end
        scba_pkg::S_CARVE: begin
          carve_a_r <= carve_a_r + blk_r;
          carve_n_r <= carve_n_r - NW'(1);
        end
        scba_pkg::S_POP: begin
          heads_r[cls_r] <= lr_data;
          ores_r         <= addr_r;
          if (outst_r != CMAX) outst_r <= outst_r + CW'(1);
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = ovld_r;
  assign out_tdata  = {3'b000, ost_r, ores_r};
  assign out_tuser  = orel_r;

  // Checks
  assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r != scba_pkg::S_IDLE || ovld_r)
    else $error("request dropped");
  assert property (@(posedge clk) disable iff (!rst_n)
    ovld_r && ost_r != scba_pkg::ST_OK |-> ores_r == '0)
    else $error("address on error");
  assert property (@(posedge clk) disable iff (!rst_n)
    ovld_r && orel_r |-> outst_r == '0 && pages_r == '0)
    else $error("release incomplete");
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == scba_pkg::S_CARVE |-> carve_n_r != '0)
    else $error("carve count underflow");
endmodule

@@ bench/tb_top.sv @@
// Testbench: size-class block allocator, directed table then random traffic
// checked against a behavioural predictor.
`timescale 1ns / 1ps
module tb_top;
  localparam int PAGE_SIZE    = scba_pkg::PAGE_SIZE;
  localparam int NUM_PAGES    = scba_pkg::NUM_PAGES;
  localparam int MIN_BLOCK    = scba_pkg::MIN_BLOCK;
  localparam int NUM_CLASSES  = scba_pkg::NUM_CLASSES;
  localparam int HEADER_BYTES = scba_pkg::HEADER_BYTES;
  localparam int ADDR_W       = scba_pkg::ADDR_W;
  localparam int SIZE_W       = scba_pkg::SIZE_W;
  localparam int CNT_W        = scba_pkg::CNT_W;

  localparam logic FN_ALLOC = 1'b0;
  localparam logic FN_FREE  = 1'b1;
  localparam int LINK_DEPTH = NUM_PAGES * PAGE_SIZE / MIN_BLOCK;
  localparam int CNT_MAX    = (1 << CNT_W) - 1;
  localparam int WDOG_LIMIT = 20000;
  localparam int N_RANDOM   = 1450;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    scba_pkg::status_t status;
    logic              released;
  } alloc_resp_t;

  typedef struct {
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] size;
  } live_blk_t;

  typedef struct {
    logic              fn;
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] addr;
    logic              typed;
    alloc_resp_t       resp;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [31:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic out_tuser;

  // Predictor state
  logic [ADDR_W:0] heads [NUM_CLASSES];
  logic [ADDR_W:0] links [LINK_DEPTH];
  int pages_used;
  int blocks_out;

  alloc_resp_t pending_resp[$];
  live_blk_t   live_blks[$];
  int errors = 0;
  int wdog = 0;
  int burst_left = 0;
  int sent = 0;

  size_class_block_allocator dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Work out the response of one request and advance the allocator state
  task automatic alloc_predict(input logic fn, input logic [SIZE_W-1:0] sz,
                               input logic [ADDR_W-1:0] ba, output alloc_resp_t r);
    int need;
    int blk;
    int c;
    int base;
    int n;
    logic bad;
    logic [ADDR_W-1:0] h;
    r = '{addr: '0, status: scba_pkg::ST_OK, released: 1'b0};
    need = int'(sz) + HEADER_BYTES;
    blk = MIN_BLOCK;
    c = 0;
    while (need > blk && c < NUM_CLASSES) begin
      blk = blk << 1;
      c++;
    end
    bad = (c >= NUM_CLASSES) || ((PAGE_SIZE - HEADER_BYTES) / blk == 0);
    if (fn == FN_ALLOC) begin
      if (bad) begin
        r.status = scba_pkg::ST_TOO_LARGE;
      end else begin
        if (pages_used == 0) pages_used = 1;
        if (!heads[c][ADDR_W]) begin
          if (pages_used >= NUM_PAGES) begin
            r.status = scba_pkg::ST_NO_PAGES;
          end else begin
            // carve a fresh page into a linked chain, lowest block first
            base = pages_used * PAGE_SIZE + HEADER_BYTES;
            n = (PAGE_SIZE - HEADER_BYTES) / blk;
            pages_used++;
            for (int k = 0; k < n; k++)
              links[((base + k * blk) / MIN_BLOCK) % LINK_DEPTH] =
                (k + 1 < n) ? {1'b1, ADDR_W'(base + (k + 1) * blk)} : '0;
            heads[c] = {1'b1, ADDR_W'(base)};
          end
        end
        if (r.status == scba_pkg::ST_OK) begin
          h = heads[c][ADDR_W-1:0];
          heads[c] = links[(h / MIN_BLOCK) % LINK_DEPTH];
          r.addr = h;
          if (blocks_out < CNT_MAX) blocks_out++;
        end
      end
    end else if (blocks_out == 0) begin
      r.status = scba_pkg::ST_NONE_OUT;
    end else if (bad) begin
      r.status = scba_pkg::ST_TOO_LARGE;
    end else begin
      links[(ba / MIN_BLOCK) % LINK_DEPTH] = heads[c];
      heads[c] = {1'b1, ba};
      blocks_out--;
      if (blocks_out == 0) begin
        foreach (heads[i]) heads[i] = '0;
        pages_used = 0;
        r.released = 1'b1;
      end
    end
  endtask

  // Offer one request beat, honouring the burst/gap pattern, then predict
  task automatic send_req(input logic fn, input logic [SIZE_W-1:0] sz,
                          input logic [ADDR_W-1:0] ba, input logic typed,
                          input alloc_resp_t typed_resp);
    alloc_resp_t r;
    if (burst_left == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 20);
    end
    in_tvalid = 1'b1;
    in_tuser  = fn;
    in_tdata  = {ba, sz};
    do @(posedge clk); while (!in_tready);
    alloc_predict(fn, sz, ba, r);
    pending_resp.push_back(typed ? typed_resp : r);
    if (fn == FN_ALLOC && r.status == scba_pkg::ST_OK) live_blks.push_back('{r.addr, sz});
    if (r.released) live_blks.delete();
    burst_left--;
    sent++;
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic send_rand_alloc();
    send_req(FN_ALLOC,
             SIZE_W'($urandom_range(0, (MIN_BLOCK << $urandom_range(0, 7)) - HEADER_BYTES)),
             ADDR_W'($urandom), 1'b0, '0);
  endtask

  task automatic free_live();
    int i;
    live_blk_t b;
    i = $urandom_range(0, live_blks.size() - 1);
    b = live_blks[i];
    live_blks.delete(i);
    send_req(FN_FREE, b.size, b.addr, 1'b0, '0);
  endtask

  // Receiver stall pattern: switches among four out_tready modes, picked at random.
  int rx_cyc = 0;
  int rx_mode = 0;
  always @(negedge clk) begin
    rx_cyc <= rx_cyc + 1;
    if (rx_cyc % 64 == 0) rx_mode <= $urandom_range(0, 3);
    case (rx_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 1) == 1);
      2: out_tready <= ($urandom_range(0, 7) != 0);
      default: out_tready <= (rx_cyc % 5 < 2);
    endcase
  end

  // Check each response beat and run the idle watchdog
  always @(posedge clk) begin
    alloc_resp_t want;
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) wdog <= 0;
    else wdog <= wdog + 1;
    if (wdog > WDOG_LIMIT) begin
      $display("size_class_block_allocator regression: fail");
      $finish;
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_resp.size() == 0) begin
        $error("response beat with nothing expected");
        errors++;
      end else begin
        want = pending_resp.pop_front();
        if (out_tdata[18:0] !== want.addr) begin
          $error("result_addr: expected %0h, got %0h", want.addr, out_tdata[18:0]);
          errors++;
        end
        if (out_tdata[20:19] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_tdata[20:19]);
          errors++;
        end
        if (out_tuser !== want.released) begin
          $error("all_released: expected %0b, got %0b", want.released, out_tuser);
          errors++;
        end
      end
    end
  end

  dir_row_t dir_rows[$];

  initial begin
    int kind;
    int r;
    foreach (heads[i]) heads[i] = '0;
    foreach (links[i]) links[i] = '0;
    pages_used = 0;
    blocks_out = 0;

    dir_rows = '{
      '{FN_FREE,  13'd0,    19'd0,      1'b1, '{19'd0, scba_pkg::ST_NONE_OUT, 1'b0}},
      '{FN_ALLOC, 13'd8191, 19'h7FFFF,  1'b1, '{19'd0, scba_pkg::ST_TOO_LARGE, 1'b0}},
      '{FN_ALLOC, 13'd4093, 19'd0,      1'b1, '{19'd0, scba_pkg::ST_TOO_LARGE, 1'b0}},
      '{FN_ALLOC, 13'd0,    19'd0,      1'b1, '{19'd8196, scba_pkg::ST_OK, 1'b0}},
      '{FN_ALLOC, 13'd28,   19'd0,      1'b1, '{19'd8228, scba_pkg::ST_OK, 1'b0}},
      '{FN_ALLOC, 13'd29,   19'd0,      1'b1, '{19'd16388, scba_pkg::ST_OK, 1'b0}},
      '{FN_ALLOC, 13'd4092, 19'd0,      1'b1, '{19'd24580, scba_pkg::ST_OK, 1'b0}},
      '{FN_FREE,  13'd8191, 19'd8196,   1'b1, '{19'd0, scba_pkg::ST_TOO_LARGE, 1'b0}},
      '{FN_FREE,  13'd4093, 19'd8196,   1'b1, '{19'd0, scba_pkg::ST_TOO_LARGE, 1'b0}},
      '{FN_FREE,  13'd0,    19'd8196,   1'b0, '0},
      '{FN_ALLOC, 13'd0,    19'h7FFFF,  1'b0, '0},
      // foreign address pushed, then popped again
      '{FN_FREE,  13'd100,  19'h7FFFF,  1'b0, '0},
      '{FN_ALLOC, 13'd100,  19'd0,      1'b0, '0},
      '{FN_ALLOC, 13'd1000, 19'd0,      1'b0, '0},
      '{FN_FREE,  13'd1000, 19'h7FFFF,  1'b0, '0},
      '{FN_FREE,  13'd28,   19'd8228,   1'b0, '0},
      '{FN_FREE,  13'd29,   19'd16388,  1'b0, '0},
      '{FN_FREE,  13'd4092, 19'd24580,  1'b0, '0},
      // last outstanding block goes back: everything released
      '{FN_FREE,  13'd0,    19'd8196,   1'b0, '0},
      '{FN_FREE,  13'd100,  19'h40000,  1'b0, '0},
      '{FN_FREE,  13'd100,  19'h7FFFF,  1'b0, '0},
      '{FN_FREE,  13'd5,    19'h7FFFF,  1'b1, '{19'd0, scba_pkg::ST_NONE_OUT, 1'b0}}
    };

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i])
      send_req(dir_rows[i].fn, dir_rows[i].size, dir_rows[i].addr,
               dir_rows[i].typed, dir_rows[i].resp);

    // Hold off until every directed response has come back
    wait (pending_resp.size() == 0);
    @(negedge clk);

    // Run the arena out of pages: one largest-class block per page
    repeat (NUM_PAGES + 3) send_req(FN_ALLOC, 13'd4092, '0, 1'b0, '0);
    for (int s = 0; s < 4; s++) send_rand_alloc();

    while (sent < N_RANDOM) begin
      kind = $urandom_range(0, 9);
      if (kind == 0 && live_blks.size() > 0) begin
        // hold off until the block is quiet, then drain to release
        wait (pending_resp.size() == 0);
        @(negedge clk);
        while (live_blks.size() > 0) free_live();
      end else begin
        repeat (60) begin
          r = $urandom_range(0, 99);
          if (r < 45 || (r < 85 && live_blks.size() == 0)) send_rand_alloc();
          else if (r < 85) free_live();
          else if (r < 92) send_req(FN_ALLOC, SIZE_W'($urandom), ADDR_W'($urandom), 1'b0, '0);
          else send_req(FN_FREE, SIZE_W'($urandom), ADDR_W'($urandom), 1'b0, '0);
        end
      end
    end

    wait (pending_resp.size() == 0);
    repeat (300) @(posedge clk);
    if (errors == 0) $display("size_class_block_allocator regression: pass");
    else $display("size_class_block_allocator regression: fail");
    $finish;
  end
endmodule

@@ filelist.f @@
rtl/scba_pkg.sv
rtl/scba_ram.sv
rtl/size_class_block_allocator.sv
bench/tb_top.sv
